// ===== hdl/slc_pkg.sv =====
`default_nettype none

package slc_pkg;

	// breathing wave period, one triangle up and down
	localparam int BREATH_HALF_TICKS = 20;
	localparam int BREATH_PERIOD     = 2 * BREATH_HALF_TICKS;
	localparam int BREATH_W          = $clog2(BREATH_PERIOD);

	// field widths
	localparam int LEVEL_W = 8;
	localparam int HOLD_W  = 8;
	localparam int HALF_W  = 4;
	localparam int BLINK_W = HALF_W + 1;
	localparam int SLOT_W  = 2;

	// register port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// register defaults
	localparam logic [HOLD_W-1:0]  LONG_PRESS_RST      = 8'd30;
	localparam logic [HOLD_W-1:0]  VERY_LONG_PRESS_RST = 8'd120;
	localparam logic [LEVEL_W-1:0] WAITING_LEVEL_RST   = 8'd51;
	localparam logic [HALF_W-1:0]  BLINK_HALF_RST      = 4'd3;

	// player slot codes
	localparam logic [SLOT_W-1:0] SLOT0 = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT1 = 2'd1;

	// register index, byte address bits [3:2]
	typedef enum logic [1:0] {
		REG_LONG_PRESS      = 2'd0,
		REG_VERY_LONG_PRESS = 2'd1,
		REG_WAITING_LEVEL   = 2'd2,
		REG_BLINK_HALF      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [HOLD_W-1:0]  long_press_ticks;
		logic [HOLD_W-1:0]  very_long_press_ticks;
		logic [LEVEL_W-1:0] waiting_level;
		logic [HALF_W-1:0]  blink_half_ticks;
	} cfg_t;

	typedef logic [BREATH_PERIOD-1:0][LEVEL_W-1:0] breath_table_t;

	// red level of the triangle breathing wave for each phase
	function automatic breath_table_t build_breath_table();
		breath_table_t t;
		int tri_v;
		for (int p = 0; p < BREATH_PERIOD; p++) begin
			tri_v = (p <= BREATH_HALF_TICKS) ? p : BREATH_PERIOD - p;
			t[p] = LEVEL_W'((tri_v * 255) / BREATH_HALF_TICKS);
		end
		return t;
	endfunction

	localparam breath_table_t BREATH_TABLE = build_breath_table();

endpackage

`default_nettype wire

// ===== hdl/status_led_and_long_press_controller.sv =====
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle when the output is not stalled, set by the
// single evaluation stage that updates the hold, blink and breathing counters
// and the result register together.
// Reset: clears both valid flags and all counters, registers return to defaults.
`default_nettype none

module status_led_and_long_press_controller
	import slc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               button_pressed,
	input  wire logic [SLOT_W-1:0]  pairing_slot,
	input  wire logic               slot0_connected,
	input  wire logic               slot0_assigned,
	input  wire logic               slot1_connected,
	input  wire logic               slot1_assigned,
	input  wire logic               portal_active,
	input  wire logic               host_connected,
	input  wire logic [LEVEL_W-1:0] color_red,
	input  wire logic [LEVEL_W-1:0] color_green,
	input  wire logic [LEVEL_W-1:0] color_blue,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [LEVEL_W-1:0] player0_level,
	output logic      [LEVEL_W-1:0] player1_level,
	output logic      [LEVEL_W-1:0] red_level,
	output logic      [LEVEL_W-1:0] green_level,
	output logic      [LEVEL_W-1:0] blue_level,
	output logic                    start_config_request,
	output logic                    wifi_reset_request
);

	cfg_t cfg;

	slc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// input register
	logic               valid_s1;
	logic               pressed_s1;
	logic [SLOT_W-1:0]  pairing_s1;
	logic               c0_s1, a0_s1, c1_s1, a1_s1;
	logic               cfg_mode_s1;
	logic               host_s1;
	logic [LEVEL_W-1:0] cr_s1, cg_s1, cb_s1;

	// result register
	logic               valid_s2;
	logic [LEVEL_W-1:0] p0_s2, p1_s2, r_s2, g_s2, b_s2;
	logic               start_s2, wifi_s2;

	// tick state
	logic [HOLD_W-1:0]   hold_q;
	logic [BREATH_W-1:0] breath_q;
	logic [BLINK_W-1:0]  blink_q;

	logic in_take;
	logic adv;

	// stage 1 moves on when the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pressed_s1  <= button_pressed;
			pairing_s1  <= pairing_slot;
			c0_s1       <= slot0_connected;
			a0_s1       <= slot0_assigned;
			c1_s1       <= slot1_connected;
			a1_s1       <= slot1_assigned;
			cfg_mode_s1 <= portal_active;
			host_s1     <= host_connected;
			cr_s1       <= color_red;
			cg_s1       <= color_green;
			cb_s1       <= color_blue;
		end
	end

	// blink phase, a half period of zero counts as one
	logic [HALF_W-1:0]  half;
	logic [BLINK_W:0]   blink_sum;
	logic [BLINK_W-1:0] blink_next;
	logic               blink_on;

	always_comb begin
		half       = (cfg.blink_half_ticks == '0) ? HALF_W'(1) : cfg.blink_half_ticks;
		blink_sum  = {1'b0, blink_q} + (BLINK_W + 1)'(1);
		blink_next = (blink_sum >= {1'b0, half, 1'b0}) ? '0 : blink_sum[BLINK_W-1:0];
		blink_on   = blink_next < {1'b0, half};
	end

	// breathing phase
	logic [BREATH_W-1:0] breath_next;

	assign breath_next = (breath_q == BREATH_W'(BREATH_PERIOD - 1)) ? '0
		: breath_q + BREATH_W'(1);

	// hold counter, saturates at the very long threshold
	logic [HOLD_W-1:0] hold_next;
	logic              start_req;
	logic              wifi_req;

	always_comb begin
		if (!pressed_s1) begin
			hold_next = '0;
		end else if (hold_q < cfg.very_long_press_ticks) begin
			hold_next = hold_q + HOLD_W'(1);
		end else begin
			hold_next = hold_q;
		end
		start_req = pressed_s1 && (hold_next == cfg.long_press_ticks) && !cfg_mode_s1;
		wifi_req  = pressed_s1 && (hold_next == cfg.very_long_press_ticks);
	end

	// player LED level for one slot
	function automatic logic [LEVEL_W-1:0] player_level(
		input logic [SLOT_W-1:0]  slot,
		input logic [SLOT_W-1:0]  pairing,
		input logic               on,
		input logic               connected,
		input logic               assigned,
		input logic [LEVEL_W-1:0] waiting
	);
		logic [LEVEL_W-1:0] lvl;
		if (pairing == slot) begin
			lvl = on ? LEVEL_MAX : '0;
		end else if (connected) begin
			lvl = LEVEL_MAX;
		end else if (assigned) begin
			lvl = waiting;
		end else begin
			lvl = '0;
		end
		return lvl;
	endfunction

	logic [LEVEL_W-1:0] p0_next, p1_next;
	logic [LEVEL_W-1:0] r_next, g_next, b_next;

	always_comb begin
		p0_next = player_level(SLOT0, pairing_s1, blink_on, c0_s1, a0_s1, cfg.waiting_level);
		p1_next = player_level(SLOT1, pairing_s1, blink_on, c1_s1, a1_s1, cfg.waiting_level);
	end

	// rgb: breathing red in config mode, solid red without host, else given color
	always_comb begin
		if (cfg_mode_s1) begin
			r_next = BREATH_TABLE[breath_next];
			g_next = '0;
			b_next = '0;
		end else if (!host_s1) begin
			r_next = LEVEL_MAX;
			g_next = '0;
			b_next = '0;
		end else begin
			r_next = cr_s1;
			g_next = cg_s1;
			b_next = cb_s1;
		end
	end

	// state advances once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= '0;
			breath_q <= '0;
			blink_q  <= '0;
		end else if (adv) begin
			hold_q   <= hold_next;
			breath_q <= breath_next;
			blink_q  <= blink_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s2    <= p0_next;
			p1_s2    <= p1_next;
			r_s2     <= r_next;
			g_s2     <= g_next;
			b_s2     <= b_next;
			start_s2 <= start_req;
			wifi_s2  <= wifi_req;
		end
	end

	assign out_valid            = valid_s2;
	assign player0_level        = p0_s2;
	assign player1_level        = p1_s2;
	assign red_level            = r_s2;
	assign green_level          = g_s2;
	assign blue_level           = b_s2;
	assign start_config_request = start_s2;
	assign wifi_reset_request   = wifi_s2;

endmodule

`default_nettype wire

// ===== hdl/slc_regs.sv =====
`default_nettype none

module slc_regs
	import slc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks      <= LONG_PRESS_RST;
			cfg_q.very_long_press_ticks <= VERY_LONG_PRESS_RST;
			cfg_q.waiting_level         <= WAITING_LEVEL_RST;
			cfg_q.blink_half_ticks      <= BLINK_HALF_RST;
		end else if (wr_en) begin
			case (idx)
				REG_LONG_PRESS:      cfg_q.long_press_ticks      <= pwdata[HOLD_W-1:0];
				REG_VERY_LONG_PRESS: cfg_q.very_long_press_ticks <= pwdata[HOLD_W-1:0];
				REG_WAITING_LEVEL:   cfg_q.waiting_level         <= pwdata[LEVEL_W-1:0];
				REG_BLINK_HALF:      cfg_q.blink_half_ticks      <= pwdata[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (idx)
			REG_LONG_PRESS:      prdata = DATA_W'(cfg_q.long_press_ticks);
			REG_VERY_LONG_PRESS: prdata = DATA_W'(cfg_q.very_long_press_ticks);
			REG_WAITING_LEVEL:   prdata = DATA_W'(cfg_q.waiting_level);
			REG_BLINK_HALF:      prdata = DATA_W'(cfg_q.blink_half_ticks);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/slc_checker.sv =====
`default_nettype none

module slc_checker
	import slc_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [LEVEL_W-1:0] red_level,
	input wire logic [LEVEL_W-1:0] player0_level
);

	// a stalled result stays valid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(red_level) && $stable(player0_level))
		else $error("result payload changed while stalled");

	// input only stalls when the result register is full and held
	assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled with free result register");

	// an accepted request reaches the output when the output is not stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted request did not reach the output");

endmodule

bind status_led_and_long_press_controller slc_checker u_slc_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
	import slc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_CAP = 40;

	// one status snapshot, as driven on the request channel
	typedef struct packed {
		logic               button_pressed;
		logic [SLOT_W-1:0]  pairing_slot;
		logic               slot0_connected;
		logic               slot0_assigned;
		logic               slot1_connected;
		logic               slot1_assigned;
		logic               portal_active;
		logic               host_connected;
		logic [LEVEL_W-1:0] color_red;
		logic [LEVEL_W-1:0] color_green;
		logic [LEVEL_W-1:0] color_blue;
	} tick_t;

	// LED levels and requests for one tick
	typedef struct packed {
		logic [LEVEL_W-1:0] player0_level;
		logic [LEVEL_W-1:0] player1_level;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
		logic               start_config_request;
		logic               wifi_reset_request;
	} levels_t;

	// tracks hold, blink and breathing state and holds the expected LED levels
	class led_board;
		cfg_t              regs;
		logic [HOLD_W-1:0] hold_count;
		int                breath_phase;
		int                blink_phase;
		levels_t           expected_levels[$];
		int                mismatches;

		function new();
			regs.long_press_ticks      = LONG_PRESS_RST;
			regs.very_long_press_ticks = VERY_LONG_PRESS_RST;
			regs.waiting_level         = WAITING_LEVEL_RST;
			regs.blink_half_ticks      = BLINK_HALF_RST;
			hold_count   = '0;
			breath_phase = 0;
			blink_phase  = 0;
			mismatches   = 0;
		endfunction

		task flag_mismatch(string what, int got, int want);
			if (mismatches < PRINT_CAP)
				$display("mismatch %s: got %0d expected %0d", what, got, want);
			mismatches++;
		endtask

		function void set_reg(reg_idx_t idx, logic [7:0] value);
			case (idx)
				REG_LONG_PRESS:      regs.long_press_ticks = value;
				REG_VERY_LONG_PRESS: regs.very_long_press_ticks = value;
				REG_WAITING_LEVEL:   regs.waiting_level = value;
				REG_BLINK_HALF:      regs.blink_half_ticks = value[HALF_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [LEVEL_W-1:0] slot_level(logic [SLOT_W-1:0] slot,
				logic [SLOT_W-1:0] pairing, bit lit, logic connected, logic assigned);
			if (pairing == slot) return lit ? LEVEL_MAX : '0;
			if (connected) return LEVEL_MAX;
			if (assigned) return regs.waiting_level;
			return '0;
		endfunction

		// advance the state by one accepted request and queue its levels
		function void note_tick(tick_t t);
			int      half;
			int      ramp;
			bit      lit;
			levels_t e;
			half = (regs.blink_half_ticks == 0) ? 1 : int'(regs.blink_half_ticks);
			blink_phase = blink_phase + 1;
			if (blink_phase >= 2 * half) blink_phase = 0;
			breath_phase = breath_phase + 1;
			if (breath_phase >= 2 * BREATH_HALF_TICKS) breath_phase = 0;

			e = '0;
			if (t.button_pressed) begin
				if (hold_count < regs.very_long_press_ticks) hold_count = hold_count + 1'b1;
				e.start_config_request = (hold_count == regs.long_press_ticks) && !t.portal_active;
				e.wifi_reset_request   = (hold_count == regs.very_long_press_ticks);
			end else begin
				hold_count = '0;
			end

			lit = blink_phase < half;
			e.player0_level = slot_level(SLOT0, t.pairing_slot, lit,
				t.slot0_connected, t.slot0_assigned);
			e.player1_level = slot_level(SLOT1, t.pairing_slot, lit,
				t.slot1_connected, t.slot1_assigned);

			if (t.portal_active) begin
				ramp = (breath_phase <= BREATH_HALF_TICKS) ? breath_phase
					: 2 * BREATH_HALF_TICKS - breath_phase;
				e.red_level = LEVEL_W'((ramp * 255) / BREATH_HALF_TICKS);
			end else if (!t.host_connected) begin
				e.red_level = LEVEL_MAX;
			end else begin
				e.red_level   = t.color_red;
				e.green_level = t.color_green;
				e.blue_level  = t.color_blue;
			end
			expected_levels.push_back(e);
		endfunction

		task check_levels(levels_t got);
			levels_t want;
			if (expected_levels.size() == 0) begin
				flag_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_levels.pop_front();
				if (got.player0_level !== want.player0_level)
					flag_mismatch("player0_level", got.player0_level, want.player0_level);
				if (got.player1_level !== want.player1_level)
					flag_mismatch("player1_level", got.player1_level, want.player1_level);
				if (got.red_level !== want.red_level)
					flag_mismatch("red_level", got.red_level, want.red_level);
				if (got.green_level !== want.green_level)
					flag_mismatch("green_level", got.green_level, want.green_level);
				if (got.blue_level !== want.blue_level)
					flag_mismatch("blue_level", got.blue_level, want.blue_level);
				if (got.start_config_request !== want.start_config_request)
					flag_mismatch("start_config_request", got.start_config_request,
						want.start_config_request);
				if (got.wifi_reset_request !== want.wifi_reset_request)
					flag_mismatch("wifi_reset_request", got.wifi_reset_request,
						want.wifi_reset_request);
			end
		endtask

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	tick_t              req = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	levels_t            res;

	led_board sb;
	int       send_idle_pct = 0;
	int       stall_pct = 0;
	int       cycles = 0;
	int       run_left = 0;
	bit       run_pressed = 0;

	status_led_and_long_press_controller u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.button_pressed       (req.button_pressed),
		.pairing_slot         (req.pairing_slot),
		.slot0_connected      (req.slot0_connected),
		.slot0_assigned       (req.slot0_assigned),
		.slot1_connected      (req.slot1_connected),
		.slot1_assigned       (req.slot1_assigned),
		.portal_active        (req.portal_active),
		.host_connected       (req.host_connected),
		.color_red            (req.color_red),
		.color_green          (req.color_green),
		.color_blue           (req.color_blue),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.player0_level        (res.player0_level),
		.player1_level        (res.player1_level),
		.red_level            (res.red_level),
		.green_level          (res.green_level),
		.blue_level           (res.blue_level),
		.start_config_request (res.start_config_request),
		.wifi_reset_request   (res.wifi_reset_request)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: check accepted levels, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_levels(res);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// offer one request, with random idle cycles ahead of it
	task automatic send_tick(tick_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		req      <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sb.note_tick(t);
	endtask

	// random snapshot; the button follows held and released runs
	function automatic tick_t next_tick(int max_run);
		tick_t t;
		if (run_left == 0) begin
			run_pressed = ($urandom_range(99) < 70);
			run_left = run_pressed ? $urandom_range(max_run, 1) : $urandom_range(3, 1);
		end
		run_left--;
		t.button_pressed  = run_pressed;
		if ($urandom_range(99) < 3) t.button_pressed = !run_pressed;
		t.pairing_slot    = SLOT_W'($urandom_range(3));
		t.slot0_connected = 1'($urandom_range(1));
		t.slot0_assigned  = 1'($urandom_range(1));
		t.slot1_connected = 1'($urandom_range(1));
		t.slot1_assigned  = 1'($urandom_range(1));
		t.portal_active   = ($urandom_range(99) < 25);
		t.host_connected  = ($urandom_range(99) < 80);
		t.color_red       = LEVEL_W'($urandom());
		t.color_green     = LEVEL_W'($urandom());
		t.color_blue      = LEVEL_W'($urandom());
		return t;
	endfunction

	task automatic run_random(int count, int max_run);
		repeat (count) send_tick(next_tick(max_run));
	endtask

	// wait until every expected result is in and the pipeline has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write one register, then read it back
	task automatic write_reg(reg_idx_t idx, logic [7:0] value);
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] want;
		data = $urandom();
		if (idx == REG_BLINK_HALF) begin
			data[HALF_W-1:0] = value[HALF_W-1:0];
			want = DATA_W'(value[HALF_W-1:0]);
		end else begin
			data[7:0] = value;
			want = DATA_W'(value);
		end
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== want) sb.flag_mismatch("register readback", prdata, want);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic configure(logic [7:0] long_ticks, logic [7:0] very_long_ticks,
			logic [7:0] waiting, logic [7:0] blink_half);
		drain();
		write_reg(REG_LONG_PRESS, long_ticks);
		write_reg(REG_VERY_LONG_PRESS, very_long_ticks);
		write_reg(REG_WAITING_LEVEL, waiting);
		write_reg(REG_BLINK_HALF, blink_half);
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		stall_pct     = receiver_pct;
	endtask

	// field extremes, pairing and slot states, breathing, both thresholds
	task automatic directed_ticks();
		tick_t t;
		// blank status with the host absent
		t = '0;
		t.pairing_slot = 2'd2;
		send_tick(t);
		// every flag but button and portal high, every color bit high, pairing code with no slot
		t = '1;
		t.button_pressed = 1'b0;
		t.portal_active  = 1'b0;
		send_tick(t);
		// slot 0 pairing, slot 1 waiting
		t = '0;
		t.pairing_slot   = SLOT0;
		t.slot1_assigned = 1'b1;
		t.host_connected = 1'b1;
		t.color_red      = 8'h5A;
		t.color_green    = 8'hA5;
		t.color_blue     = 8'h0F;
		repeat (2) send_tick(t);
		// slot 1 pairing, slot 0 connected
		t.pairing_slot    = SLOT1;
		t.slot0_connected = 1'b1;
		repeat (2) send_tick(t);
		// breathing wave
		t.portal_active = 1'b1;
		repeat (3) send_tick(t);
		// held through both thresholds into saturation, then released
		t = '0;
		t.host_connected = 1'b1;
		t.pairing_slot   = 2'd2;
		t.button_pressed = 1'b1;
		repeat (7) send_tick(t);
		t.button_pressed = 1'b0;
		send_tick(t);
		// config mode suppresses the start pulse; left held at saturation
		t.button_pressed = 1'b1;
		t.portal_active  = 1'b1;
		repeat (4) send_tick(t);
	endtask

	task automatic held_ticks(int count, bit pressed);
		tick_t t;
		t = '0;
		t.host_connected = 1'b1;
		t.pairing_slot   = SLOT1;
		t.button_pressed = pressed;
		repeat (count) send_tick(t);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(7, 60);
		configure(8'd2, 8'd4, 8'hA5, 8'd1);
		directed_ticks();
		// threshold lowered below a held count: count holds, no request
		configure(8'd2, 8'd2, 8'h00, 8'd1);
		held_ticks(2, 1'b1);
		held_ticks(1, 1'b0);
		// zero thresholds and zero blink half period
		configure(8'd0, 8'd0, 8'hFF, 8'd0);
		held_ticks(3, 1'b1);
		held_ticks(1, 1'b0);
		held_ticks(2, 1'b1);
		// long blink period, then shortened under a high phase
		configure(8'd1, 8'd3, 8'd51, 8'd15);
		run_random(28, 6);

		configure(8'd30, 8'd120, 8'd51, 8'd3);
		run_random(300, 125);
		configure(8'd255, 8'd255, 8'd255, 8'd15);
		run_random(300, 260);

		set_idling(60, 7);
		configure(8'd1, 8'd1, 8'd0, 8'd1);
		run_random(150, 4);
		configure(8'd0, 8'd0, 8'($urandom()), 8'd0);
		run_random(100, 4);

		set_idling(0, 0);
		configure(8'($urandom_range(20, 1)), 8'($urandom_range(30, 1)),
			8'($urandom()), 8'($urandom_range(15, 1)));
		run_random(200, 34);
		configure(8'd7, 8'd9, 8'd200, 8'd2);
		run_random(250, 12);

		drain();
		if (sb.mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/slc_pkg.sv
hdl/slc_regs.sv
hdl/status_led_and_long_press_controller.sv
hdl/slc_checker.sv
tb/tb_top.sv
